[design/nec_ir_edge_decoder_assert.svh]
// ============================================================================
// NEC IR edge decoder assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ============================================================================
`ifndef NEC_IR_EDGE_DECODER_ASSERT_SVH
`define NEC_IR_EDGE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define NEC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/nec_ir_pkg.sv]
// ============================================================================
// NEC IR decoder package
// Phase and command codes, register indexes and frame constants.
// ============================================================================
package nec_ir_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_LEADER   = 3'd1,
        PH_DATA     = 3'd2,
        PH_COMPLETE = 3'd3,
        PH_ERROR    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CMD_EDGE       = 2'd0,
        CMD_TAKE       = 2'd1,
        CMD_SOFT_RESET = 2'd2,
        CMD_NONE       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_ENABLE      = 3'd0,
        REG_LEADER_HIGH = 3'd1,
        REG_LEADER_LOW  = 3'd2,
        REG_BIT_ZERO    = 3'd3,
        REG_BIT_ONE     = 3'd4,
        REG_TOLERANCE   = 3'd5
    } reg_idx_t;

    localparam int unsigned CFG_W       = 16;
    localparam int unsigned FRAME_BITS  = 32;
    localparam int unsigned BIT_CNT_W   = 6;
    localparam logic [7:0]  INV_MASK    = 8'hFF;

    localparam logic [CFG_W-1:0] RST_LEADER_HIGH = 16'd9000;
    localparam logic [CFG_W-1:0] RST_LEADER_LOW  = 16'd4500;
    localparam logic [CFG_W-1:0] RST_BIT_ZERO    = 16'd562;
    localparam logic [CFG_W-1:0] RST_BIT_ONE     = 16'd1687;
    localparam logic [CFG_W-1:0] RST_TOLERANCE   = 16'd200;

endpackage

[design/nec_ir_edge_decoder.sv]
// ============================================================================
// NEC IR edge decoder
// Decodes NEC infrared frames from timestamped line edges: interval
// measurement, leader and bit window matching, LSB-first shifting and the
// address/command inverse check.
// ============================================================================
//
//  channel   ports                               direction  handshake
//  --------  ----------------------------------  ---------  ------------------
//  input     s_command s_edge_time s_edge_level  in         s_valid / s_ready
//  result    m_frame_done m_data_ready ...       out        m_valid / m_ready
//  config    cfg_addr cfg_wdata                  in         cfg_we (no wait)
//
//  One item per cycle sustained unless the result stalls. The item lands in
//  the input register, then one pass of subtract/compare/shift logic
//  updates the decoder state and loads the result register.
//  Synchronous active-low reset clears both pipeline slots, the decoder
//  state and loads the register defaults.
//  A stalled result holds the result register; an occupied input register
//  then holds too and s_ready drops until m_ready frees the slot.
//
`include "nec_ir_edge_decoder_assert.svh"

module nec_ir_edge_decoder
    import nec_ir_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,

    // config write port
    input  logic             cfg_we,
    input  logic [2:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,

    // input items
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_command,
    input  logic [31:0]      s_edge_time,
    input  logic             s_edge_level,

    // result items
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_frame_done,
    output logic             m_data_ready,
    output logic [7:0]       m_address_byte,
    output logic [7:0]       m_command_byte,
    output logic [7:0]       m_address_inverse,
    output logic [7:0]       m_command_inverse
);

    // Compare width: wide enough for the period and for nominal + tolerance.
    localparam int unsigned CMP_W = (TIME_WIDTH > CFG_W + 1) ? TIME_WIDTH : CFG_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic             enable_reg;
    logic [CFG_W-1:0] leader_high_reg;
    logic [CFG_W-1:0] leader_low_reg;
    logic [CFG_W-1:0] bit_zero_reg;
    logic [CFG_W-1:0] bit_one_reg;
    logic [CFG_W-1:0] tolerance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b1;
            leader_high_reg <= RST_LEADER_HIGH;
            leader_low_reg  <= RST_LEADER_LOW;
            bit_zero_reg    <= RST_BIT_ZERO;
            bit_one_reg     <= RST_BIT_ONE;
            tolerance_reg   <= RST_TOLERANCE;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_ENABLE:      enable_reg      <= cfg_wdata[0];
                REG_LEADER_HIGH: leader_high_reg <= cfg_wdata;
                REG_LEADER_LOW:  leader_low_reg  <= cfg_wdata;
                REG_BIT_ZERO:    bit_zero_reg    <= cfg_wdata;
                REG_BIT_ONE:     bit_one_reg     <= cfg_wdata;
                REG_TOLERANCE:   tolerance_reg   <= cfg_wdata;
                default: begin
                    // indexes past the list are dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: input slot feeds the result slot
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    cmd_t                  in_cmd_reg;
    logic [TIME_WIDTH-1:0] in_time_reg;
    logic                  in_level_reg;

    logic                  out_valid_reg;
    logic                  out_done_reg;
    logic                  out_ready_flag_reg;
    logic [FRAME_BITS-1:0] out_word_reg;

    logic out_free;   // result slot can take a new item this cycle
    logic proc;       // input slot item is decoded this cycle

    assign out_free = !out_valid_reg || m_ready;
    assign proc     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload only; loads with the handshake
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg   <= cmd_t'(s_command);
            in_time_reg  <= s_edge_time[TIME_WIDTH-1:0];
            in_level_reg <= s_edge_level;
        end
    end

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    phase_t                phase_reg,        phase_next;
    logic [FRAME_BITS-1:0] shift_word_reg,   shift_word_next;
    logic [BIT_CNT_W-1:0]  bits_reg,         bits_next;
    logic [TIME_WIDTH-1:0] prev_time_reg,    prev_time_next;
    logic [FRAME_BITS-1:0] result_word_reg,  result_word_next;
    logic                  result_valid_reg, result_valid_next;

    logic                  done_next;
    logic                  ready_flag_next;
    logic [TIME_WIDTH-1:0] period;
    logic [CMP_W-1:0]      period_w;
    logic                  win_leader_high;
    logic                  win_leader_low;
    logic                  win_zero;
    logic                  win_one;
    logic                  inv_ok;

    // Inclusive window nominal +/- tol, lower bound floored at zero.
    function automatic logic in_window(
        input logic [CMP_W-1:0] p,
        input logic [CFG_W-1:0] nom,
        input logic [CFG_W-1:0] tol
    );
        logic [CFG_W:0] lo;
        logic [CFG_W:0] hi;
        lo = (nom > tol) ? {1'b0, nom - tol} : '0;
        hi = {1'b0, nom} + {1'b0, tol};
        return (p >= CMP_W'(lo)) && (p <= CMP_W'(hi));
    endfunction

    // interval wraps modulo 2^TIME_WIDTH
    assign period   = in_time_reg - prev_time_reg;
    assign period_w = CMP_W'(period);

    assign win_leader_high = in_window(period_w, leader_high_reg, tolerance_reg);
    assign win_leader_low  = in_window(period_w, leader_low_reg,  tolerance_reg);
    assign win_zero        = in_window(period_w, bit_zero_reg,    tolerance_reg);
    assign win_one         = in_window(period_w, bit_one_reg,     tolerance_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            shift_word_reg   <= '0;
            bits_reg         <= '0;
            prev_time_reg    <= '0;
            result_word_reg  <= '0;
            result_valid_reg <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            shift_word_reg   <= shift_word_next;
            bits_reg         <= bits_next;
            prev_time_reg    <= prev_time_next;
            result_word_reg  <= result_word_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        shift_word_next   = shift_word_reg;
        bits_next         = bits_reg;
        prev_time_next    = prev_time_reg;
        result_word_next  = result_word_reg;
        result_valid_next = result_valid_reg;
        done_next         = 1'b0;
        ready_flag_next   = result_valid_reg;
        inv_ok            = 1'b0;

        if (proc) begin
            case (in_cmd_reg)
                CMD_EDGE: begin
                    if (enable_reg) begin
                        prev_time_next = in_time_reg;
                        case (phase_reg)
                            PH_IDLE: begin
                                if (in_level_reg) begin
                                    phase_next = PH_LEADER;
                                end
                            end
                            PH_LEADER: begin
                                if (!in_level_reg) begin
                                    // leader mark ends on the falling edge
                                    phase_next = win_leader_high ? PH_LEADER : PH_IDLE;
                                end else if (win_leader_low) begin
                                    phase_next      = PH_DATA;
                                    shift_word_next = '0;
                                    bits_next       = '0;
                                end else begin
                                    phase_next = PH_IDLE;
                                end
                            end
                            PH_DATA: begin
                                // rising edges only move the timestamp
                                if (!in_level_reg) begin
                                    if (!win_zero && !win_one) begin
                                        phase_next = PH_ERROR;
                                    end else begin
                                        // zero window wins when both match
                                        if (!win_zero) begin
                                            shift_word_next[bits_reg[4:0]] = 1'b1;
                                        end
                                        bits_next = bits_reg + 1'b1;
                                        if (bits_next[BIT_CNT_W-1]) begin
                                            // full frame: latch it, then check
                                            result_word_next = shift_word_next;
                                            inv_ok = ((shift_word_next[7:0] ^
                                                       shift_word_next[23:16]) == INV_MASK) &&
                                                     ((shift_word_next[15:8] ^
                                                       shift_word_next[31:24]) == INV_MASK);
                                            if (inv_ok) begin
                                                result_valid_next = 1'b1;
                                                phase_next        = PH_COMPLETE;
                                                done_next         = 1'b1;
                                            end else begin
                                                phase_next = PH_ERROR;
                                            end
                                        end
                                    end
                                end
                            end
                            PH_COMPLETE, PH_ERROR: begin
                                phase_next        = PH_IDLE;
                                result_valid_next = 1'b0;
                            end
                            default: begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                    ready_flag_next = result_valid_next;
                end
                CMD_TAKE: begin
                    ready_flag_next   = result_valid_reg;
                    result_valid_next = 1'b0;
                    phase_next        = PH_IDLE;
                end
                CMD_SOFT_RESET: begin
                    // timestamp and stored result word survive
                    phase_next        = PH_IDLE;
                    shift_word_next   = '0;
                    bits_next         = '0;
                    result_valid_next = 1'b0;
                    ready_flag_next   = 1'b0;
                end
                default: begin
                    ready_flag_next = result_valid_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_done_reg       <= done_next;
            out_ready_flag_reg <= ready_flag_next;
            out_word_reg       <= result_word_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_frame_done      = out_done_reg;
    assign m_data_ready      = out_ready_flag_reg;
    assign m_address_byte    = out_word_reg[7:0];
    assign m_command_byte    = out_word_reg[15:8];
    assign m_address_inverse = out_word_reg[23:16];
    assign m_command_inverse = out_word_reg[31:24];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `NEC_ASSERT_NOW(a_done_sets_ready, m_valid && m_frame_done, m_data_ready,
        "frame_done without data_ready")

    `NEC_ASSERT_NOW(a_done_inverse_ok, m_valid && m_frame_done,
        ((m_address_byte ^ m_address_inverse) == INV_MASK) &&
        ((m_command_byte ^ m_command_inverse) == INV_MASK),
        "frame_done on a frame failing the inverse check")

    `NEC_ASSERT_NOW(a_complete_has_result, phase_reg == PH_COMPLETE, result_valid_reg,
        "complete phase without a valid result")

    `NEC_ASSERT_NOW(a_data_count_bound, phase_reg == PH_DATA, !bits_reg[BIT_CNT_W-1],
        "bit count past a frame while in data phase")

    `NEC_ASSERT_NEXT(a_soft_reset_clears, proc && (in_cmd_reg == CMD_SOFT_RESET),
        (phase_reg == PH_IDLE) && !result_valid_reg && (bits_reg == '0),
        "soft reset left decoder state behind")

endmodule

[dv/nec_ir_edge_decoder_chk.sv]
`timescale 1ns / 1ps
// ============================================================================
// NEC IR edge decoder checker
// Tracks register writes and accepted input items and keeps its own copy of
// the decoder. Each result item is compared with the oldest decode still due.
// ============================================================================
module nec_ir_edge_decoder_chk
    import nec_ir_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_we,
    input  logic [2:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,

    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [1:0]       s_command,
    input  logic [31:0]      s_edge_time,
    input  logic             s_edge_level,

    input  logic             m_valid,
    input  logic             m_ready,
    input  logic             m_frame_done,
    input  logic             m_data_ready,
    input  logic [7:0]       m_address_byte,
    input  logic [7:0]       m_command_byte,
    input  logic [7:0]       m_address_inverse,
    input  logic [7:0]       m_command_inverse,

    output int unsigned      fail_count,
    output int unsigned      pending
);

    localparam logic [31:0] TIME_MASK = 32'hFFFF_FFFF >> (32 - TIME_WIDTH);

    typedef struct packed {
        logic       frame_done;
        logic       data_ready;
        logic [7:0] address_byte;
        logic [7:0] command_byte;
        logic [7:0] address_inverse;
        logic [7:0] command_inverse;
    } decode_out_t;

    // register copy
    logic             enable_q;
    logic [CFG_W-1:0] leader_high_q;
    logic [CFG_W-1:0] leader_low_q;
    logic [CFG_W-1:0] zero_nom_q;
    logic [CFG_W-1:0] one_nom_q;
    logic [CFG_W-1:0] tol_q;

    // decoder state copy
    phase_t               phase_q;
    logic [31:0]          shift_q;
    logic [BIT_CNT_W-1:0] bit_cnt_q;
    logic [31:0]          last_edge_q;
    logic [31:0]          frame_word_q;
    logic                 frame_valid_q;

    decode_out_t decodes_due[$];
    decode_out_t seen;
    decode_out_t want;
    int unsigned mismatches;

    // Inclusive window, lower bound floored at zero.
    function automatic logic fits(logic [31:0] span, logic [CFG_W-1:0] nom);
        logic [CFG_W:0] lo;
        logic [CFG_W:0] hi;
        lo = (nom > tol_q) ? {1'b0, nom - tol_q} : '0;
        hi = {1'b0, nom} + {1'b0, tol_q};
        return (span >= 32'(lo)) && (span <= 32'(hi));
    endfunction

    // One enabled edge; returns 1 when it closes a frame that passes.
    function automatic logic edge_step(logic [31:0] t, logic lvl);
        logic [31:0] span;
        logic        b;
        span = (t - last_edge_q) & TIME_MASK;
        last_edge_q = t;
        case (phase_q)
            PH_IDLE: begin
                if (lvl)
                    phase_q = PH_LEADER;
            end
            PH_LEADER: begin
                if (!lvl) begin
                    phase_q = fits(span, leader_high_q) ? PH_LEADER : PH_IDLE;
                end else if (fits(span, leader_low_q)) begin
                    phase_q   = PH_DATA;
                    shift_q   = '0;
                    bit_cnt_q = '0;
                end else begin
                    phase_q = PH_IDLE;
                end
            end
            PH_DATA: begin
                if (!lvl) begin
                    if (fits(span, zero_nom_q)) begin
                        b = 1'b0;
                    end else if (fits(span, one_nom_q)) begin
                        b = 1'b1;
                    end else begin
                        phase_q = PH_ERROR;
                        return 1'b0;
                    end
                    shift_q[bit_cnt_q[4:0]] = shift_q[bit_cnt_q[4:0]] | b;
                    bit_cnt_q = bit_cnt_q + 1'b1;
                    if (bit_cnt_q >= FRAME_BITS) begin
                        frame_word_q = shift_q;
                        if (((shift_q[7:0] ^ shift_q[23:16]) == INV_MASK) &&
                            ((shift_q[15:8] ^ shift_q[31:24]) == INV_MASK)) begin
                            frame_valid_q = 1'b1;
                            phase_q       = PH_COMPLETE;
                            return 1'b1;
                        end
                        phase_q = PH_ERROR;
                    end
                end
            end
            PH_COMPLETE, PH_ERROR: begin
                phase_q       = PH_IDLE;
                frame_valid_q = 1'b0;
            end
            default: phase_q = PH_IDLE;
        endcase
        return 1'b0;
    endfunction

    function automatic decode_out_t decode_step(cmd_t c, logic [31:0] t, logic lvl);
        decode_out_t r;
        r.frame_done = 1'b0;
        case (c)
            CMD_EDGE: begin
                if (enable_q)
                    r.frame_done = edge_step(t & TIME_MASK, lvl);
                r.data_ready = frame_valid_q;
            end
            CMD_TAKE: begin
                r.data_ready  = frame_valid_q;
                frame_valid_q = 1'b0;
                phase_q       = PH_IDLE;
            end
            CMD_SOFT_RESET: begin
                phase_q       = PH_IDLE;
                shift_q       = '0;
                bit_cnt_q     = '0;
                frame_valid_q = 1'b0;
                r.data_ready  = 1'b0;
            end
            default: r.data_ready = frame_valid_q;
        endcase
        {r.command_inverse, r.address_inverse, r.command_byte, r.address_byte} =
            frame_word_q;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            enable_q      = 1'b1;
            leader_high_q = RST_LEADER_HIGH;
            leader_low_q  = RST_LEADER_LOW;
            zero_nom_q    = RST_BIT_ZERO;
            one_nom_q     = RST_BIT_ONE;
            tol_q         = RST_TOLERANCE;
            phase_q       = PH_IDLE;
            shift_q       = '0;
            bit_cnt_q     = '0;
            last_edge_q   = '0;
            frame_word_q  = '0;
            frame_valid_q = 1'b0;
            decodes_due.delete();
            mismatches    = 0;
        end else begin
            if (cfg_we) begin
                case (reg_idx_t'(cfg_addr))
                    REG_ENABLE:      enable_q      = cfg_wdata[0];
                    REG_LEADER_HIGH: leader_high_q = cfg_wdata;
                    REG_LEADER_LOW:  leader_low_q  = cfg_wdata;
                    REG_BIT_ZERO:    zero_nom_q    = cfg_wdata;
                    REG_BIT_ONE:     one_nom_q     = cfg_wdata;
                    REG_TOLERANCE:   tol_q         = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                decodes_due.push_back(decode_step(cmd_t'(s_command), s_edge_time,
                                                  s_edge_level));
            if (m_valid && m_ready) begin
                seen = {m_frame_done, m_data_ready, m_address_byte, m_command_byte,
                        m_address_inverse, m_command_inverse};
                if (decodes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result item with no decode due: %h", $time, seen);
                end else begin
                    want = decodes_due.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch exp done %b ready %b bytes %h %h %h %h",
                                     $time, want.frame_done, want.data_ready,
                                     want.address_byte, want.command_byte,
                                     want.address_inverse, want.command_inverse);
                            $display("%0t:          got done %b ready %b bytes %h %h %h %h",
                                     $time, seen.frame_done, seen.data_ready,
                                     seen.address_byte, seen.command_byte,
                                     seen.address_inverse, seen.command_inverse);
                        end
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= decodes_due.size();
    end

endmodule

[dv/nec_ir_edge_decoder_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// NEC IR edge decoder testbench
// Drives timestamped edges, takes and soft resets into the decoder under
// several register settings and idle patterns; a checker beside the block
// predicts and compares every result item.
// ============================================================================
module nec_ir_edge_decoder_tb
    import nec_ir_pkg::*;
();

    localparam int unsigned TIME_WIDTH     = 32;
    localparam int unsigned RESET_CYCLES   = 9;
    localparam int unsigned QUIET_CYCLES   = 8;     // well past the pipeline latency
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned PHASES         = 6;
    localparam int unsigned PHASE_ITEMS    = 60;

    // one register setting, kept wide for interval arithmetic
    typedef struct packed {
        int unsigned enable;
        int unsigned leader_high;
        int unsigned leader_low;
        int unsigned zero_nom;
        int unsigned one_nom;
        int unsigned tol;
    } knob_set_t;

    logic             aclk;
    logic             aresetn      = 1'b0;
    logic             cfg_we       = 1'b0;
    logic [2:0]       cfg_addr     = '0;
    logic [CFG_W-1:0] cfg_wdata    = '0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    logic [1:0]       s_command    = CMD_NONE;
    logic [31:0]      s_edge_time  = '0;
    logic             s_edge_level = 1'b0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    logic             m_frame_done;
    logic             m_data_ready;
    logic [7:0]       m_address_byte;
    logic [7:0]       m_command_byte;
    logic [7:0]       m_address_inverse;
    logic [7:0]       m_command_inverse;

    int unsigned mismatch_total;
    int unsigned decodes_pending;

    knob_set_t   knobs;             // setting the stimulus is shaped for
    logic [31:0] now_us;            // running edge timestamp, wraps
    int unsigned items_sent  = 0;
    int unsigned tx_idle_pct = 37;
    int unsigned rx_idle_pct = 50;
    int unsigned stall_cycles = 0;

    nec_ir_edge_decoder #(
        .TIME_WIDTH(TIME_WIDTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_edge_time       (s_edge_time),
        .s_edge_level      (s_edge_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_done      (m_frame_done),
        .m_data_ready      (m_data_ready),
        .m_address_byte    (m_address_byte),
        .m_command_byte    (m_command_byte),
        .m_address_inverse (m_address_inverse),
        .m_command_inverse (m_command_inverse)
    );

    nec_ir_edge_decoder_chk #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_chk (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_edge_time       (s_edge_time),
        .s_edge_level      (s_edge_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_done      (m_frame_done),
        .m_data_ready      (m_data_ready),
        .m_address_byte    (m_address_byte),
        .m_command_byte    (m_command_byte),
        .m_address_inverse (m_address_inverse),
        .m_command_inverse (m_command_inverse),
        .fail_count        (mismatch_total),
        .pending           (decodes_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Result side: back-pressure drawn fresh every cycle.
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= rx_idle_pct);

    // Watchdog: too long without any item moving on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic knob_set_t default_knobs();
        knob_set_t k;
        k.enable      = 1;
        k.leader_high = 32'(RST_LEADER_HIGH);
        k.leader_low  = 32'(RST_LEADER_LOW);
        k.zero_nom    = 32'(RST_BIT_ZERO);
        k.one_nom     = 32'(RST_BIT_ONE);
        k.tol         = 32'(RST_TOLERANCE);
        return k;
    endfunction

    // Interval for a nominal: inside the window (often right on a bound) or,
    // when bad, just outside it.
    function automatic int unsigned span_for(int unsigned nom, logic bad);
        int unsigned lo;
        int unsigned hi;
        lo = (nom > knobs.tol) ? nom - knobs.tol : 0;
        hi = nom + knobs.tol;
        if (bad) begin
            if (lo > 0 && $urandom_range(1) == 1)
                return lo - $urandom_range(1, (lo < 50) ? lo : 50);
            return hi + $urandom_range(1, 50);
        end
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // Presents one item and holds it until accepted. Valid stays up when
    // the next item follows with no idle gap.
    task automatic push_item(cmd_t c, logic [31:0] t, logic lvl);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= c;
        s_edge_time  <= t;
        s_edge_level <= lvl;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic edge_after(int unsigned delta, logic lvl);
        now_us = now_us + delta;
        push_item(CMD_EDGE, now_us, lvl);
    endtask

    // Drop valid and wait until every predicted decode has come back.
    // The first look comes after the next clock edge so a just-accepted item is counted.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (decodes_pending != 0);
    endtask

    task automatic write_knobs(knob_set_t k);
        reg_idx_t    idx;
        int unsigned val;
        for (int i = 0; i <= int'(REG_TOLERANCE); i++) begin
            idx = reg_idx_t'(i);
            case (idx)
                REG_ENABLE:      val = k.enable;
                REG_LEADER_HIGH: val = k.leader_high;
                REG_LEADER_LOW:  val = k.leader_low;
                REG_BIT_ZERO:    val = k.zero_nom;
                REG_BIT_ONE:     val = k.one_nom;
                default:         val = k.tol;
            endcase
            cfg_we    <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= CFG_W'(val);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        knobs = k;
    endtask

    // One NEC frame: get to idle, leader, 32 LSB-first bits. Some frames
    // carry a bad interval (sequence ends there) or a flipped bit so the
    // inverse check fails.
    task automatic send_frame();
        logic [7:0]  adr;
        logic [7:0]  cmd;
        logic [31:0] word;
        int          flip;
        int          flaw;
        adr = 8'($urandom_range(255));
        cmd = 8'($urandom_range(255));
        if ($urandom_range(3) == 0)
            adr = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
        if ($urandom_range(3) == 0)
            cmd = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
        word = {~cmd, ~adr, cmd, adr};
        if ($urandom_range(4) == 0) begin
            flip = int'($urandom_range(31));
            word[flip] = ~word[flip];
        end
        flaw = ($urandom_range(4) == 0) ? int'($urandom_range(33)) : -1;

        // a take or soft reset always lands in idle; a low edge usually does
        case ($urandom_range(9))
            0, 1, 2, 3, 4: push_item(CMD_TAKE, $urandom, 1'($urandom_range(1)));
            5, 6, 7:       push_item(CMD_SOFT_RESET, $urandom, 1'($urandom_range(1)));
            default:       edge_after($urandom_range(20000, 1), 1'b0);
        endcase
        edge_after($urandom_range(20000, 1), 1'b1);
        edge_after(span_for(knobs.leader_high, flaw == 0), 1'b0);
        if (flaw == 0)
            return;
        edge_after(span_for(knobs.leader_low, flaw == 1), 1'b1);
        if (flaw == 1)
            return;
        for (int i = 0; i < FRAME_BITS; i++) begin
            edge_after(span_for(word[i] ? knobs.one_nom : knobs.zero_nom, flaw == i + 2),
                       1'b0);
            if (flaw == i + 2)
                return;
            // rising edges inside data only move the timestamp
            if (i < FRAME_BITS - 1)
                edge_after($urandom_range(2000, 1), 1'b1);
        end
        if ($urandom_range(2) != 0)
            push_item(CMD_TAKE, $urandom, 1'($urandom_range(1)));
    endtask

    task automatic send_noise();
        logic lvl;
        lvl = 1'($urandom_range(1));
        case ($urandom_range(5))
            0: push_item(CMD_NONE, $urandom, lvl);
            1: push_item(CMD_TAKE, $urandom, lvl);
            2: push_item(CMD_SOFT_RESET, $urandom, lvl);
            3: begin
                now_us = $urandom;
                push_item(CMD_EDGE, now_us, lvl);
            end
            default: edge_after($urandom_range(3000, 0), lvl);
        endcase
    endtask

    initial begin
        knob_set_t   k;
        int unsigned phase_end;
        int unsigned halfway;
        logic        paused;

        knobs = default_knobs();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed, reset settings ----
        push_item(CMD_NONE, 32'hFFFF_FFFF, 1'b1);
        push_item(CMD_TAKE, 32'h0000_0000, 1'b0);       // nothing held yet
        now_us = 32'hFFFF_E000;
        edge_after(0, 1'b0);                             // low edge in idle stays idle
        edge_after(1, 1'b1);                             // enter leader
        edge_after(knobs.leader_high + knobs.tol, 1'b0); // upper bound, time wraps past 0
        edge_after(knobs.leader_low - knobs.tol, 1'b1);  // lower bound, into data
        edge_after(knobs.zero_nom - knobs.tol, 1'b0);    // zero bit at its lower bound
        edge_after(700, 1'b1);
        edge_after(knobs.one_nom + knobs.tol, 1'b0);     // one bit at its upper bound
        edge_after(700, 1'b1);
        edge_after(knobs.one_nom + knobs.tol + 1, 1'b0); // fits no window: error
        edge_after(300, 1'b1);                           // error back to idle
        edge_after(300, 1'b1);                           // leader again
        edge_after(knobs.leader_high - knobs.tol - 1, 1'b0); // leader too short
        edge_after(300, 1'b1);
        edge_after(knobs.leader_high, 1'b0);
        edge_after(knobs.leader_high, 1'b0);             // second low part still fits
        edge_after(knobs.leader_low + knobs.tol + 1, 1'b1);  // leader low too long
        push_item(CMD_SOFT_RESET, now_us, 1'b0);
        push_item(CMD_TAKE, now_us, 1'b1);

        // ---- random phases: settings change each time, idle pattern every second ----
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            repeat (QUIET_CYCLES) @(posedge aclk);
            k = default_knobs();
            case (ph)
                1: begin                                 // exact windows, extreme nominals
                    k.tol         = 0;
                    k.leader_high = 65535;
                    k.leader_low  = 0;
                    k.zero_nom    = 0;
                    k.one_nom     = 65535;
                end
                2: begin                                 // widest windows, all overlap
                    k.tol         = 65535;
                    k.leader_high = 0;
                    k.leader_low  = 65535;
                    k.zero_nom    = 65535;
                    k.one_nom     = 0;
                end
                3: begin                                 // disabled, edges ignored
                    k.enable      = 0;
                    k.leader_high = $urandom_range(65535);
                    k.leader_low  = $urandom_range(65535);
                    k.zero_nom    = $urandom_range(65535);
                    k.one_nom     = $urandom_range(65535);
                    k.tol         = $urandom_range(65535);
                end
                4: begin                                 // random, separable windows
                    k.tol         = $urandom_range(300);
                    k.zero_nom    = $urandom_range(3000, 100);
                    k.one_nom     = k.zero_nom + 2 * k.tol + $urandom_range(3000, 1);
                    k.leader_high = $urandom_range(65535);
                    k.leader_low  = $urandom_range(65535);
                end
                default: ;                               // reset values
            endcase
            write_knobs(k);

            tx_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 50 : 0;
            rx_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 37 : 0;
            now_us      = $urandom;
            phase_end   = items_sent + PHASE_ITEMS;
            halfway     = items_sent + PHASE_ITEMS / 2;
            paused      = 1'b0;
            while (items_sent < phase_end) begin
                // hold the sender until the pipe is empty once per phase
                if (!paused && items_sent >= halfway) begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(9) < 7)
                    send_frame();
                else
                    repeat ($urandom_range(6, 1)) send_noise();
            end
        end

        drain();
        repeat (QUIET_CYCLES) @(posedge aclk);
        if (mismatch_total == 0 && decodes_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/nec_ir_pkg.sv
design/nec_ir_edge_decoder.sv
dv/nec_ir_edge_decoder_chk.sv
dv/nec_ir_edge_decoder_tb.sv
